// File: rtl/core/cdc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared constants and the month length lookup for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned STAT_W  = 3;

	localparam logic [YEAR_W-1:0] YEAR_MIN     = 12'd1900;
	localparam logic [YEAR_W-1:0] YEAR_MAX_SET = 12'd2100;
	localparam logic [YEAR_W-1:0] YEAR_LIMIT   = 12'd4095;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_YEAR  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_MONTH = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_DAY   = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

	// Operation codes.
	localparam logic OP_SET     = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Number of days in a month; zero for a month code outside 1 to 12.
	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		begin
			case (month)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
				4'd2:                                      len = leap ? 5'd29 : 5'd28;
				default:                                   len = 5'd0;
			endcase
			return len;
		end
	endfunction

endpackage

// File: rtl/core/calendar_date_counter.sv
// ----------------------------------------------------------------------------
// Calendar date counter
// Keeps a Gregorian date; loads a checked date or advances it day by day.
// ----------------------------------------------------------------------------
// A set transfer gives its result in the cycle after acceptance. An advance
// transfer of N days walks through S_STEP before its result shows in S_DONE,
// because the single day-step unit moves the date by one day per cycle.
// Throughput: one item at a time; the input stalls until the result is taken.
// Reset: the date clears to 1 January 1900 and the sequencer returns to idle.
module calendar_date_counter
	import cdc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [DAY_W-1:0]    set_day,
	input  logic [MONTH_W-1:0]  set_month,
	input  logic [YEAR_W-1:0]   set_year,
	input  logic [15:0]         day_count,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [DAY_W-1:0]    cur_day,
	output logic [MONTH_W-1:0]  cur_month,
	output logic [YEAR_W-1:0]   cur_year,
	output logic [STAT_W-1:0]   status
);

	// The sequencer is idle, walks days in STEP, or holds a result in DONE.
	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [DAY_W-1:0]       day_q;
	logic [MONTH_W-1:0]     month_q;
	logic [YEAR_W-1:0]      year_q;
	logic [STAT_W-1:0]      status_q;
	logic [COUNT_BITS-1:0]  days_left_q;

	// The leap rule needs the year modulo 100 and modulo 400. Rather than
	// divide, the block tracks the year within its century and the century
	// modulo four; both are loaded on a set and follow each year increment.
	logic [6:0]             yr_mod100_q;
	logic [1:0]             cent_mod4_q;

	logic                   in_xfer;
	logic                   out_xfer;

	// Set-path checks, evaluated on the incoming fields.
	logic                   set_year_ok;
	logic                   set_month_ok;
	logic                   set_leap;
	logic [DAY_W-1:0]       set_dim;
	logic                   set_day_ok;
	logic [7:0]             set_ofs;
	logic [6:0]             set_mod100;
	logic [1:0]             set_cent;

	// Day-step unit, evaluated on the stored date.
	logic                   cur_leap;
	logic [DAY_W-1:0]       cur_dim;

	logic [COUNT_BITS-1:0]  count_load;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);

	assign cur_day   = day_q;
	assign cur_month = month_q;
	assign cur_year  = year_q;
	assign status    = status_q;

	assign count_load = COUNT_BITS'(day_count);

	always_comb begin
		set_year_ok  = (set_year >= YEAR_MIN) && (set_year <= YEAR_MAX_SET);
		set_month_ok = (set_month != 4'd0) && (set_month <= MONTH_DEC);
		// Within 1900 to 2100 only 1900 and 2100 are century years that are
		// not leap; 2000 divides by 400.
		set_leap     = (set_year[1:0] == 2'd0) && (set_year != YEAR_MIN) &&
			(set_year != YEAR_MAX_SET);
		set_dim      = days_in_month(set_month, set_leap);
		set_day_ok   = (set_day != 5'd0) && (set_day <= set_dim);

		// Offset from 1900 fits in eight bits once the year has passed its check.
		set_ofs = 8'(set_year - YEAR_MIN);
		if (set_ofs >= 8'd200) begin
			set_mod100 = 7'(set_ofs - 8'd200);
			set_cent   = 2'd1;
		end else if (set_ofs >= 8'd100) begin
			set_mod100 = 7'(set_ofs - 8'd100);
			set_cent   = 2'd0;
		end else begin
			set_mod100 = 7'(set_ofs);
			set_cent   = 2'd3;
		end

		cur_leap = (yr_mod100_q == 7'd0) ? (cent_mod4_q == 2'd0) : (year_q[1:0] == 2'd0);
		cur_dim  = days_in_month(month_q, cur_leap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			day_q       <= 5'd1;
			month_q     <= 4'd1;
			year_q      <= YEAR_MIN;
			yr_mod100_q <= 7'd0;
			cent_mod4_q <= 2'd3;
			days_left_q <= '0;
			status_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						status_q <= ST_OK;
						if (op == OP_ADVANCE) begin
							days_left_q <= count_load;
							state_q     <= S_STEP;
						end else begin
							// An invalid date leaves every field of the stored date alone.
							if (!set_year_ok) begin
								status_q <= ST_BAD_YEAR;
							end else if (!set_month_ok) begin
								status_q <= ST_BAD_MONTH;
							end else if (!set_day_ok) begin
								status_q <= ST_BAD_DAY;
							end else begin
								day_q       <= set_day;
								month_q     <= set_month;
								year_q      <= set_year;
								yr_mod100_q <= set_mod100;
								cent_mod4_q <= set_cent;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_STEP: begin
					if (days_left_q == '0) begin
						state_q <= S_DONE;
					end else if (day_q < cur_dim) begin
						day_q       <= day_q + 5'd1;
						days_left_q <= days_left_q - 1'b1;
					end else if (month_q < MONTH_DEC) begin
						month_q     <= month_q + 4'd1;
						day_q       <= 5'd1;
						days_left_q <= days_left_q - 1'b1;
					end else if (year_q >= YEAR_LIMIT) begin
						// Stepping past the last representable year is refused and the
						// remaining days are dropped.
						status_q    <= ST_OVERFLOW;
						days_left_q <= '0;
						state_q     <= S_DONE;
					end else begin
						year_q      <= year_q + 12'd1;
						month_q     <= 4'd1;
						day_q       <= 5'd1;
						days_left_q <= days_left_q - 1'b1;
						if (yr_mod100_q == 7'd99) begin
							yr_mod100_q <= 7'd0;
							cent_mod4_q <= cent_mod4_q + 2'd1;
						end else begin
							yr_mod100_q <= yr_mod100_q + 7'd1;
						end
					end
				end
				S_DONE: begin
					if (out_xfer) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
